// File: rtl/core/path_curve_segment_detector_macros.svh
// ----------------------------------------------------------------------------
// Path curve segment detector - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PATH_CURVE_SEGMENT_DETECTOR_MACROS_SVH
`define PATH_CURVE_SEGMENT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcsd: implication check failed");
// next-cycle implication
`define PCSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcsd: next-cycle check failed");
`else
`define PCSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PCSD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/pcsd_pkg.sv
// ----------------------------------------------------------------------------
// pcsd_pkg
// Shared widths, codes and types of the path curve segment detector.
// ----------------------------------------------------------------------------
package pcsd_pkg;

    localparam int WINDOW_WIDTH = 5;
    localparam int HALF_SPAN    = (WINDOW_WIDTH - 1) / 2;
    localparam int INDEX_BITS   = 16;
    localparam int SLOT_W       = $clog2(WINDOW_WIDTH);
    localparam int OFF_W        = $clog2(HALF_SPAN + 1);

    localparam int COORD_W  = 32;
    localparam int POINT_W  = 2 * COORD_W;
    localparam int MAG_W    = COORD_W + 1;
    localparam int CROSS_W  = 2 * MAG_W + 1;
    localparam int DIST_W   = 2 * MAG_W + 1;
    localparam int DIV_W    = CROSS_W + 1;
    localparam int MUL_A_W  = 2 * DIST_W;
    localparam int MUL_B_W  = DIST_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ROOT_W   = (PROD_W + 1) / 2;
    localparam int RAD_W    = 30;
    localparam int THR_W    = 27;

    localparam int SQRT_REM_W = ROOT_W + 3;
    localparam int DIV_SH_W   = DIV_W + RAD_W - 1;

    localparam int MUL_CNT_W  = $clog2(MUL_B_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int DIV_CNT_W  = $clog2(RAD_W);

    localparam int S_DATA_W   = POINT_W;
    localparam int M_FIELDS_W = 2 * INDEX_BITS + 2 * RAD_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_THRESH = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_MIN    = CFG_ADDR_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pcsd_point_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PLAN, ST_RD_A, ST_RD_B, ST_RD_C, ST_LOAD_C, ST_CALC, ST_RESULT
    } pcsd_state_t;

    typedef enum logic [2:0] {
        RS_IDLE, RS_MUL, RS_CROSS, RS_SQRT, RS_CHECK, RS_DIV, RS_DONE
    } pcsd_rstate_t;

    typedef enum logic [3:0] {
        OP_U, OP_V, OP_AB_X, OP_AB_Y, OP_BC_X, OP_BC_Y, OP_CA_X, OP_CA_Y, OP_P1, OP_P2
    } pcsd_op_t;

endpackage

// File: rtl/core/pcsd_mul.sv
// ----------------------------------------------------------------------------
// pcsd_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pcsd_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pcsd_pkg::MUL_A_W-1:0] a,
    input  logic [pcsd_pkg::MUL_B_W-1:0] b,
    output logic                         done,
    output logic [pcsd_pkg::PROD_W-1:0]  p
);
    import pcsd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    ash_reg;
    logic [MUL_B_W-1:0]   bsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                ash_reg  <= PROD_W'(a);
                bsh_reg  <= b;
            end else if (busy_reg) begin
                if (bsh_reg[0]) begin
                    acc_reg <= acc_reg + ash_reg;
                end
                ash_reg <= ash_reg << 1;
                bsh_reg <= bsh_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// File: rtl/core/pcsd_isqrt.sv
// ----------------------------------------------------------------------------
// pcsd_isqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pcsd_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pcsd_pkg::PROD_W-1:0] radicand,
    output logic                        done,
    output logic [pcsd_pkg::ROOT_W-1:0] root
);
    import pcsd_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [2*ROOT_W-1:0]   rad_reg;
    logic [SQRT_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_REM_W-1:0] rem_sh;
    logic [SQRT_REM_W-1:0] trial;

    assign rem_sh = {rem_reg[SQRT_REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= (2*ROOT_W)'(radicand);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/pcsd_div.sv
// ----------------------------------------------------------------------------
// pcsd_div
// Restoring divider, one quotient bit per cycle; quotient known to fit RAD_W.
// ----------------------------------------------------------------------------
module pcsd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pcsd_pkg::ROOT_W-1:0] num,
    input  logic [pcsd_pkg::DIV_W-1:0]  den,
    output logic                        done,
    output logic [pcsd_pkg::RAD_W-1:0]  quot
);
    import pcsd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ROOT_W-1:0]    rem_reg;
    logic [DIV_SH_W-1:0]  ds_reg;
    logic [RAD_W-1:0]     q_reg;
    logic [ROOT_W-1:0]    ds_ext;

    assign ds_ext = ROOT_W'(ds_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num;
                ds_reg   <= {den, {(RAD_W-1){1'b0}}};
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (rem_reg >= ds_ext) begin
                    rem_reg <= rem_reg - ds_ext;
                    q_reg   <= {q_reg[RAD_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[RAD_W-2:0], 1'b0};
                end
                ds_reg  <= ds_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(RAD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/core/pcsd_radius.sv
// ----------------------------------------------------------------------------
// pcsd_radius
// Circumradius sequencer: r = min(rinf, isqrt(d_ab*d_bc*d_ca) / (2*|cross|)).
// ----------------------------------------------------------------------------
module pcsd_radius (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  pcsd_pkg::pcsd_point_t       pa,
    input  pcsd_pkg::pcsd_point_t       pb,
    input  pcsd_pkg::pcsd_point_t       pc,
    input  logic [pcsd_pkg::RAD_W-1:0]  rinf,
    output logic                        done,
    output logic [pcsd_pkg::RAD_W-1:0]  radius
);
    import pcsd_pkg::*;

    pcsd_rstate_t state_reg, state_next;
    pcsd_op_t     op_reg;
    logic         launch_reg;

    logic [MAG_W-1:0] e1_reg, e2_reg, f1_reg, f2_reg, g1_reg, g2_reg;
    logic             s1_reg, s2_reg;
    logic [CROSS_W-1:0] u_reg, v_reg, cr_reg, cr_calc;
    logic [DIST_W-1:0]  dab_reg, dbc_reg, dca_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [RAD_W-1:0]   rinf_reg, radius_reg;

    logic signed [MAG_W-1:0] de1, de2, df1, df2, dg1, dg2;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [RAD_W-1:0]   quot;
    logic [DIV_W+RAD_W-1:0] dsh;
    logic mul_start, mul_done, sq_start, sq_done, dv_start, dv_done, ovf;

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // coordinate differences, sign extended to 33 bits
    assign de1 = {pb.x[COORD_W-1], pb.x} - {pa.x[COORD_W-1], pa.x};
    assign de2 = {pb.y[COORD_W-1], pb.y} - {pa.y[COORD_W-1], pa.y};
    assign df1 = {pc.y[COORD_W-1], pc.y} - {pa.y[COORD_W-1], pa.y};
    assign df2 = {pc.x[COORD_W-1], pc.x} - {pa.x[COORD_W-1], pa.x};
    assign dg1 = {pb.x[COORD_W-1], pb.x} - {pc.x[COORD_W-1], pc.x};
    assign dg2 = {pb.y[COORD_W-1], pb.y} - {pc.y[COORD_W-1], pc.y};

    always_comb begin
        if (s1_reg != s2_reg) begin
            cr_calc = u_reg + v_reg;
        end else if (u_reg >= v_reg) begin
            cr_calc = u_reg - v_reg;
        end else begin
            cr_calc = v_reg - u_reg;
        end
    end

    assign dsh = {cr_reg, 1'b0, {RAD_W{1'b0}}};
    assign ovf = (root_reg >= ROOT_W'(dsh));

    always_comb begin
        unique case (op_reg)
            OP_U:    begin mul_a = MUL_A_W'(e1_reg);  mul_b = MUL_B_W'(f1_reg);  end
            OP_V:    begin mul_a = MUL_A_W'(e2_reg);  mul_b = MUL_B_W'(f2_reg);  end
            OP_AB_X: begin mul_a = MUL_A_W'(e1_reg);  mul_b = MUL_B_W'(e1_reg);  end
            OP_AB_Y: begin mul_a = MUL_A_W'(e2_reg);  mul_b = MUL_B_W'(e2_reg);  end
            OP_BC_X: begin mul_a = MUL_A_W'(g1_reg);  mul_b = MUL_B_W'(g1_reg);  end
            OP_BC_Y: begin mul_a = MUL_A_W'(g2_reg);  mul_b = MUL_B_W'(g2_reg);  end
            OP_CA_X: begin mul_a = MUL_A_W'(f2_reg);  mul_b = MUL_B_W'(f2_reg);  end
            OP_CA_Y: begin mul_a = MUL_A_W'(f1_reg);  mul_b = MUL_B_W'(f1_reg);  end
            OP_P1:   begin mul_a = MUL_A_W'(dab_reg); mul_b = MUL_B_W'(dbc_reg); end
            OP_P2:   begin mul_a = p_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(dca_reg); end
            default: begin mul_a = '0;                mul_b = '0;                end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RS_IDLE:  if (start) state_next = RS_MUL;
            RS_MUL: begin
                if (launch_reg && mul_done) begin
                    if (op_reg == OP_V) begin
                        state_next = RS_CROSS;
                    end else if (op_reg == OP_P2) begin
                        state_next = RS_SQRT;
                    end
                end
            end
            RS_CROSS: state_next = (cr_calc == '0) ? RS_DONE : RS_MUL;
            RS_SQRT:  if (launch_reg && sq_done) state_next = RS_CHECK;
            RS_CHECK: state_next = ovf ? RS_DONE : RS_DIV;
            RS_DIV:   if (launch_reg && dv_done) state_next = RS_DONE;
            RS_DONE:  state_next = RS_IDLE;
            default:  state_next = RS_IDLE;
        endcase
    end

    // unit strobes
    always_comb begin
        mul_start = (state_reg == RS_MUL)  && !launch_reg;
        sq_start  = (state_reg == RS_SQRT) && !launch_reg;
        dv_start  = (state_reg == RS_DIV)  && !launch_reg;
        done      = (state_reg == RS_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= RS_IDLE;
            launch_reg <= 1'b0;
            op_reg     <= OP_U;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                RS_IDLE: begin
                    if (start) begin
                        e1_reg <= mag(de1);
                        e2_reg <= mag(de2);
                        f1_reg <= mag(df1);
                        f2_reg <= mag(df2);
                        g1_reg <= mag(dg1);
                        g2_reg <= mag(dg2);
                        s1_reg <= de1[MAG_W-1] ^ df1[MAG_W-1];
                        s2_reg <= de2[MAG_W-1] ^ df2[MAG_W-1];
                        rinf_reg   <= rinf;
                        op_reg     <= OP_U;
                        launch_reg <= 1'b0;
                    end
                end
                RS_MUL: begin
                    if (!launch_reg) begin
                        launch_reg <= 1'b1;
                    end else if (mul_done) begin
                        launch_reg <= 1'b0;
                        op_reg     <= pcsd_op_t'(op_reg + 1'b1);
                        unique case (op_reg)
                            OP_U:    u_reg   <= CROSS_W'(mul_p);
                            OP_V:    v_reg   <= CROSS_W'(mul_p);
                            OP_AB_X: dab_reg <= DIST_W'(mul_p);
                            OP_AB_Y: dab_reg <= dab_reg + DIST_W'(mul_p);
                            OP_BC_X: dbc_reg <= DIST_W'(mul_p);
                            OP_BC_Y: dbc_reg <= dbc_reg + DIST_W'(mul_p);
                            OP_CA_X: dca_reg <= DIST_W'(mul_p);
                            OP_CA_Y: dca_reg <= dca_reg + DIST_W'(mul_p);
                            OP_P1:   p_reg   <= mul_p;
                            OP_P2:   p_reg   <= mul_p;
                            default: p_reg   <= mul_p;
                        endcase
                    end
                end
                RS_CROSS: begin
                    cr_reg <= cr_calc;
                    if (cr_calc == '0) radius_reg <= rinf_reg;
                end
                RS_SQRT: begin
                    if (!launch_reg) begin
                        launch_reg <= 1'b1;
                    end else if (sq_done) begin
                        launch_reg <= 1'b0;
                    end
                end
                RS_CHECK: begin
                    if (ovf) radius_reg <= rinf_reg;
                end
                RS_DIV: begin
                    if (!launch_reg) begin
                        launch_reg <= 1'b1;
                    end else if (dv_done) begin
                        launch_reg <= 1'b0;
                        radius_reg <= (quot >= rinf_reg) ? rinf_reg : quot;
                    end
                end
                RS_DONE: launch_reg <= 1'b0;
                default: launch_reg <= 1'b0;
            endcase
        end
    end

    logic [ROOT_W-1:0] sq_root;

    always_ff @(posedge aclk) begin
        if (sq_done) root_reg <= sq_root;
    end

    pcsd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    pcsd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (p_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    pcsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     (root_reg),
        .den     ({cr_reg, 1'b0}),
        .done    (dv_done),
        .quot    (quot)
    );

    assign radius = radius_reg;

endmodule

// File: rtl/core/path_curve_segment_detector.sv
// ----------------------------------------------------------------------------
// path_curve_segment_detector
// Three-point circumradius per path point with curve start/end detection.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: x, y; s_tlast: last point
//  m_      | out | m_tvalid/m_tready | m_tdata: index, radius, start, min radius;
//          |     |                   | m_tuser: curve_done; m_tlast: last_result
//  cfg_    | in  | cfg_valid/ready   | cfg_addr: register index; cfg_data: value
//
// Flow: one point is taken at a time. A radius result takes ten products on
// the bit-serial multiplier, then the square root and the divider; end
// points skip the arithmetic, and collinear triples stop after the two
// cross-product terms. The last point of a path emits up to three.
// Reset: synchronous, active low; no clearing pass, the point window is only
// read at entries of the current path. A stalled result holds the unit; a new
// point is still taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`include "path_curve_segment_detector_macros.svh"

module path_curve_segment_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    // x [31:0], y [63:32]
    input  logic [pcsd_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index [15:0], radius [45:16], curve_start [61:46],
    // curve_min_radius [91:62], zero pad above
    output logic [pcsd_pkg::M_DATA_W-1:0]   m_tdata,
    // curve_done [0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pcsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pcsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcsd_pkg::*;

    pcsd_state_t state_reg, state_next;

    // configuration
    logic [THR_W-1:0] thresh_reg, rmin_reg;
    logic [RAD_W:0]   ten_th;
    logic [RAD_W-1:0] rinf;

    // path bookkeeping
    logic [INDEX_BITS-1:0] count_reg, k_reg;
    logic                  wrapped_reg, wr_reg, last_item_reg, first_reg;
    logic [SLOT_W-1:0]     newest_reg, newest_next, pp_reg, pp_calc;
    logic [OFF_W-1:0]      off_reg;

    // window memory
    logic [POINT_W-1:0] win_mem [WINDOW_WIDTH];
    logic [POINT_W-1:0] rd_q, pa_reg, pb_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               rd_en;

    // curve tracking
    logic [RAD_W-1:0]      prev_reg, lmin_reg, r_reg;
    logic                  curve_open_reg;
    logic [INDEX_BITS-1:0] start_reg;

    // result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg, m_last_reg;

    logic in_acc, plan_first, plan_endp, out_free, out_load, final_emit;
    logic rad_start, rad_done;
    logic [RAD_W-1:0] rad_radius;

    function automatic logic [SLOT_W-1:0] win_slot(input logic [SLOT_W-1:0] top,
                                                   input logic [SLOT_W-1:0] back);
        if (top >= back) begin
            return top - back;
        end
        return SLOT_W'(top + SLOT_W'(WINDOW_WIDTH) - back);
    endfunction

    assign cfg_ready = 1'b1;
    assign ten_th = (RAD_W+1)'({thresh_reg, 3'b000}) + (RAD_W+1)'({thresh_reg, 1'b0});
    assign rinf   = ten_th[RAD_W] ? {RAD_W{1'b1}} : ten_th[RAD_W-1:0];

    assign in_acc      = s_tvalid && s_tready;
    assign newest_next = (newest_reg == SLOT_W'(WINDOW_WIDTH - 1)) ? '0 : newest_reg + 1'b1;

    // which window entries feed this emission
    always_comb begin
        plan_first = !wr_reg && (k_reg == INDEX_BITS'(off_reg));
        plan_endp  = last_item_reg && (off_reg == '0);
        pp_calc    = SLOT_W'(off_reg) + SLOT_W'(HALF_SPAN);
        if (!wr_reg && (INDEX_BITS'(pp_calc) > k_reg)) begin
            pp_calc = k_reg[SLOT_W-1:0];
        end
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign final_emit = last_item_reg && (off_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tlast || wrapped_reg || (count_reg >= INDEX_BITS'(HALF_SPAN))) begin
                        state_next = ST_PLAN;
                    end
                end
            end
            ST_PLAN:   state_next = (plan_first || plan_endp) ? ST_RESULT : ST_RD_A;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_RD_C;
            ST_RD_C:   state_next = ST_LOAD_C;
            ST_LOAD_C: state_next = ST_CALC;
            ST_CALC:   if (rad_done) state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = (last_item_reg && (off_reg != '0)) ? ST_PLAN : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        rad_start = (state_reg == ST_LOAD_C);
        out_load  = (state_reg == ST_RESULT) && out_free;
        rd_en     = 1'b0;
        rd_addr   = newest_reg;
        unique case (state_reg)
            ST_RD_A: begin rd_en = 1'b1; rd_addr = win_slot(newest_reg, pp_reg);          end
            ST_RD_B: begin rd_en = 1'b1; rd_addr = win_slot(newest_reg, SLOT_W'(off_reg)); end
            ST_RD_C: begin rd_en = 1'b1; rd_addr = newest_reg;                            end
            default: begin rd_en = 1'b0; rd_addr = newest_reg;                            end
        endcase
    end

    // curve update for the result being loaded
    logic [INDEX_BITS-1:0] j_idx, start_next, cst;
    logic [RAD_W-1:0]      lmin_next, cmin, th_ext, rmin_ext;
    logic                  on_next, cdone;

    always_comb begin
        j_idx      = k_reg - INDEX_BITS'(off_reg);
        th_ext     = RAD_W'(thresh_reg);
        rmin_ext   = RAD_W'(rmin_reg);
        on_next    = curve_open_reg;
        start_next = start_reg;
        lmin_next  = lmin_reg;
        cdone      = 1'b0;
        cst        = '0;
        cmin       = '0;
        if (!first_reg) begin
            if (!curve_open_reg && (r_reg <= th_ext) && (prev_reg > th_ext)) begin
                start_next = j_idx;
                on_next    = 1'b1;
            end else if (curve_open_reg && (prev_reg <= th_ext) && (r_reg > th_ext)) begin
                on_next   = 1'b0;
                cdone     = 1'b1;
                cst       = start_reg;
                cmin      = (lmin_reg < rmin_ext) ? rmin_ext : lmin_reg;
                lmin_next = {RAD_W{1'b1}};
            end
            if (on_next && (lmin_next > r_reg)) begin
                lmin_next = r_reg;
            end
        end
    end

    // window memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (in_acc) win_mem[newest_next] <= s_tdata[POINT_W-1:0];
        if (rd_en)  rd_q <= win_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            thresh_reg     <= THR_W'(20000);
            rmin_reg       <= THR_W'(6000);
            count_reg      <= '0;
            wrapped_reg    <= 1'b0;
            newest_reg     <= '0;
            prev_reg       <= '0;
            curve_open_reg <= 1'b0;
            start_reg      <= '0;
            lmin_reg       <= {RAD_W{1'b1}};
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    CFG_RADIUS_THRESH: thresh_reg <= cfg_data[THR_W-1:0];
                    CFG_RADIUS_MIN:    rmin_reg   <= cfg_data[THR_W-1:0];
                    default:           ;
                endcase
            end

            if (in_acc) begin
                k_reg         <= count_reg;
                wr_reg        <= wrapped_reg;
                last_item_reg <= s_tlast;
                newest_reg    <= newest_next;
                if (s_tlast) begin
                    count_reg   <= '0;
                    wrapped_reg <= 1'b0;
                    off_reg     <= (!wrapped_reg && (count_reg < INDEX_BITS'(HALF_SPAN))) ?
                                   count_reg[OFF_W-1:0] : OFF_W'(HALF_SPAN);
                end else begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == {INDEX_BITS{1'b1}}) wrapped_reg <= 1'b1;
                    off_reg   <= OFF_W'(HALF_SPAN);
                end
            end

            if (state_reg == ST_PLAN) begin
                first_reg <= plan_first;
                pp_reg    <= pp_calc;
                if (plan_first || plan_endp) r_reg <= rinf;
            end
            if (state_reg == ST_RD_B) pa_reg <= rd_q;
            if (state_reg == ST_RD_C) pb_reg <= rd_q;
            if ((state_reg == ST_CALC) && rad_done) r_reg <= rad_radius;

            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {(M_DATA_W - M_FIELDS_W)'(0), cmin, cst, r_reg, j_idx};
                m_user_reg  <= cdone;
                m_last_reg  <= final_emit;
                if (final_emit) begin
                    // path closed: curve state back to reset, open curve dropped
                    prev_reg       <= '0;
                    curve_open_reg <= 1'b0;
                    start_reg      <= '0;
                    lmin_reg       <= {RAD_W{1'b1}};
                end else begin
                    prev_reg       <= r_reg;
                    curve_open_reg <= on_next;
                    start_reg      <= start_next;
                    lmin_reg       <= lmin_next;
                end
                if (last_item_reg && (off_reg != '0)) off_reg <= off_reg - 1'b1;
            end
        end
    end

    pcsd_radius u_radius (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rad_start),
        .pa      (pcsd_point_t'(pa_reg)),
        .pb      (pcsd_point_t'(pb_reg)),
        .pc      (pcsd_point_t'(rd_q)),
        .rinf    (rinf),
        .done    (rad_done),
        .radius  (rad_radius)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // a last point always emits, so the input side is closed in the cycle after the transfer
    `PCSD_ASSERT_NXT(a_last_blocks_input, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // while the final result of a path waits, curve state stays cleared
    `PCSD_ASSERT_IMP(a_last_clears_curve, aclk, aresetn, m_tvalid && m_tlast, !curve_open_reg && (prev_reg == '0))

endmodule

// File: tb/path_curve_segment_detector_tb.sv
// ----------------------------------------------------------------------------
// path_curve_segment_detector_tb
// Streams paths of points into the curve segment detector and checks every
// radius transfer against an exact integer circumradius predictor that also
// tracks curve start and end. Sender bursts, receiver stalls and register
// changes between quiet phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_curve_segment_detector_tb;
    import pcsd_pkg::*;

    localparam logic [RAD_W-1:0] RAD_ALL_ONES = '1;

    typedef struct {
        pcsd_point_t p;
        logic        last;
    } path_pt_t;

    typedef struct {
        logic [15:0]      index;
        logic [RAD_W-1:0] radius;
        logic             done;
        logic [15:0]      start;
        logic [RAD_W-1:0] min_radius;
        logic             last_result;
    } radius_rec_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    path_curve_segment_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // points waiting for the driver, radius transfers waiting for the monitor
    path_pt_t    pending_points[$];
    radius_rec_t expected_radii[$];
    int          error_count = 0;
    int          item_count  = 0;

    // predictor copy of the block state and registers
    logic [26:0]      thresh_reg;
    logic [26:0]      min_reg;
    pcsd_point_t      win[WINDOW_WIDTH];
    int unsigned      pt_count;
    bit               wrapped;
    logic [RAD_W-1:0] prev_r;
    bit               in_curve;
    logic [15:0]      curve_first;
    logic [RAD_W-1:0] curve_min;

    function automatic logic [255:0] dist_sq(pcsd_point_t p, pcsd_point_t q);
        logic signed [69:0] dx, dy;
        logic [255:0]       mx, my;
        dx = $signed(p.x) - $signed(q.x);
        dy = $signed(p.y) - $signed(q.y);
        mx = '0; my = '0;
        mx[69:0] = dx < 0 ? -dx : dx;
        my[69:0] = dy < 0 ? -dy : dy;
        return mx * mx + my * my;
    endfunction

    // (2 * cross * r)^2 <= |ab|^2 |bc|^2 |ca|^2  <=>  r <= exact radius
    function automatic bit radius_fits(logic [255:0] c2, logic [RAD_W-1:0] r,
                                       logic [255:0] prod);
        logic [255:0] t, rr;
        rr = '0;
        rr[RAD_W-1:0] = r;
        t = c2 * rr;
        return (t * t) <= prod;
    endfunction

    function automatic logic [RAD_W-1:0] circumradius(pcsd_point_t a, pcsd_point_t b,
                                                      pcsd_point_t c,
                                                      logic [RAD_W-1:0] rinf);
        logic signed [69:0] e1, f1, e2, f2, cr;
        logic [255:0]       c2, prod;
        logic [RAD_W-1:0]   lo, hi, mid;
        e1 = $signed(b.x) - $signed(a.x);
        f1 = $signed(c.y) - $signed(a.y);
        e2 = $signed(b.y) - $signed(a.y);
        f2 = $signed(c.x) - $signed(a.x);
        cr = e1 * f1 - e2 * f2;
        if (cr == 0) return rinf;   // collinear or coincident
        c2 = '0;
        c2[69:0] = cr < 0 ? -cr : cr;
        c2 = c2 << 1;
        prod = dist_sq(a, b) * dist_sq(b, c);
        prod = prod * dist_sq(c, a);
        if (radius_fits(c2, rinf, prod)) return rinf;
        lo = '0;
        hi = rinf;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (radius_fits(c2, mid, prod)) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void clear_path_state();
        for (int i = 0; i < WINDOW_WIDTH; i++) win[i] = '0;
        pt_count    = 0;
        wrapped     = 0;
        prev_r      = '0;
        in_curve    = 0;
        curve_first = '0;
        curve_min   = RAD_ALL_ONES;
    endfunction

    // radius of point k-o, plus curve tracking; queues one expectation
    function automatic void emit_radius(int unsigned k, int unsigned o, bit last);
        logic [33:0]      rinf34;
        logic [RAD_W-1:0] rinf, r;
        int unsigned      pp;
        bit               first, endp;
        radius_rec_t      rec;
        rinf34 = 34'(thresh_reg) * 34'd10;
        rinf   = rinf34 > 34'(RAD_ALL_ONES) ? RAD_ALL_ONES : rinf34[RAD_W-1:0];
        first  = !wrapped && o == k;
        endp   = last && o == 0;
        rec.index       = 16'((k - o) & 16'hFFFF);
        rec.done        = 0;
        rec.start       = '0;
        rec.min_radius  = '0;
        rec.last_result = endp;
        if (first || endp) begin
            r = rinf;
        end else begin
            pp = o + HALF_SPAN;
            if (!wrapped && pp > k) pp = k;
            if (pp >= WINDOW_WIDTH) pp = WINDOW_WIDTH - 1;
            r = circumradius(win[pp], win[o < WINDOW_WIDTH ? o : 0], win[0], rinf);
        end
        if (!first) begin
            if (!in_curve && r <= thresh_reg && prev_r > thresh_reg) begin
                curve_first = rec.index;
                in_curve    = 1;
            end else if (in_curve && prev_r <= thresh_reg && r > thresh_reg) begin
                in_curve       = 0;
                rec.done       = 1;
                rec.start      = curve_first;
                rec.min_radius = curve_min < min_reg ? RAD_W'(min_reg) : curve_min;
                curve_min      = RAD_ALL_ONES;
            end
            if (in_curve && curve_min > r) curve_min = r;
        end
        prev_r = r;
        rec.radius = r;
        expected_radii.insert(expected_radii.size(), rec);
    endfunction

    function automatic void track_point(path_pt_t pt);
        int unsigned k, hi;
        k = pt_count & 16'hFFFF;
        for (int i = WINDOW_WIDTH - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = pt.p;
        if (pt.last) begin
            hi = HALF_SPAN;
            if (!wrapped && k < hi) hi = k;
            for (int o = hi; o >= 0; o--) emit_radius(k, o, 1);
            clear_path_state();
            return;
        end
        if (wrapped || k >= HALF_SPAN) emit_radius(k, HALF_SPAN, 0);
        pt_count = (k + 1) & 16'hFFFF;
        if (pt_count == 0) wrapped = 1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    path_pt_t cur_pt;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge aclk) begin : point_driver
        bit next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) track_point(cur_pt);   // transfer at this edge
            next_valid = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_points.size() > 0) begin
                cur_pt     = pending_points.pop_front();
                next_valid = 1;
                s_tdata   <= {cur_pt.p.y, cur_pt.p.x};
                s_tlast   <= cur_pt.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: receiver stall pattern switches between four modes at random.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_tick = 0;

    always @(posedge aclk) begin : radius_monitor
        radius_rec_t want;
        radius_rec_t got;
        bit          rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.index       = m_tdata[15:0];
                got.radius      = m_tdata[45:16];
                got.start       = m_tdata[61:46];
                got.min_radius  = m_tdata[91:62];
                got.done        = m_tuser;
                got.last_result = m_tlast;
                if (expected_radii.size() == 0) begin
                    $display("%0t: unexpected radius transfer index=%0d radius=%0d",
                             $time, got.index, got.radius);
                    error_count++;
                end else begin
                    want = expected_radii.pop_front();
                    if (got.index !== want.index) begin
                        $display("%0t: point_index expected %0d actual %0d",
                                 $time, want.index, got.index);
                        error_count++;
                    end
                    if (got.radius !== want.radius) begin
                        $display("%0t: radius (index %0d) expected %0d actual %0d",
                                 $time, want.index, want.radius, got.radius);
                        error_count++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: curve_done (index %0d) expected %0d actual %0d",
                                 $time, want.index, want.done, got.done);
                        error_count++;
                    end
                    if (got.start !== want.start) begin
                        $display("%0t: curve_start (index %0d) expected %0d actual %0d",
                                 $time, want.index, want.start, got.start);
                        error_count++;
                    end
                    if (got.min_radius !== want.min_radius) begin
                        $display("%0t: curve_min_radius (index %0d) expected %0d actual %0d",
                                 $time, want.index, want.min_radius, got.min_radius);
                        error_count++;
                    end
                    if (got.last_result !== want.last_result) begin
                        $display("%0t: last_result (index %0d) expected %0d actual %0d",
                                 $time, want.index, want.last_result, got.last_result);
                        error_count++;
                    end
                end
            end
            stall_tick++;
            if (stall_tick >= 64) begin
                stall_tick = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: rdy = 1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (stall_tick % 8) == 0;
                default: rdy = $urandom_range(0, 9) != 0;
            endcase
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_point(int x, int y, bit last);
        path_pt_t pt;
        pt.p.x  = x;
        pt.p.y  = y;
        pt.last = last;
        pending_points.insert(pending_points.size(), pt);
        item_count++;
    endtask

    // random walk: straight stretches and arcs sized around the threshold
    task automatic push_walk(int n);
        real px, py, hd, stp, turn, rad;
        int  seg_left;
        px  = $itor($signed($urandom_range(0, 2000000000))) - 1.0e9;
        py  = $itor($signed($urandom_range(0, 2000000000))) - 1.0e9;
        hd  = $itor($urandom_range(0, 6283)) / 1000.0;
        stp = $itor($urandom_range(200, 5000));
        turn = 0.0;
        seg_left = 0;
        for (int i = 0; i < n; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(2, 8);
                if ($urandom_range(0, 2) == 0) begin
                    turn = 0.0;
                end else begin
                    rad  = ($itor(thresh_reg) + 1.0) * $itor($urandom_range(10, 300)) / 100.0;
                    turn = stp / rad;
                    if (turn > 1.5) turn = 1.5;
                    if ($urandom_range(0, 1)) turn = -turn;
                end
            end
            seg_left--;
            push_point($rtoi(px), $rtoi(py), i == n - 1);
            hd = hd + turn;
            px = px + stp * $cos(hd);
            py = py + stp * $sin(hd);
        end
    endtask

    task automatic push_random_paths(int n_items);
        int target, n;
        target = item_count + n_items;
        while (item_count < target) begin
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 6);   // full-range noise path
                for (int i = 0; i < n; i++)
                    push_point($urandom, $urandom, i == n - 1);
            end else begin
                push_walk($urandom_range(3, 25));
            end
        end
    endtask

    // no results outstanding and no point in flight, then allow the unit to finish
    task automatic wait_quiet();
        while (pending_points.size() > 0 || s_tvalid || expected_radii.size() > 0)
            @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [26:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= 32'(value);
        do @(posedge aclk); while (!cfg_ready);
        if (addr == CFG_RADIUS_THRESH) thresh_reg = value;
        else if (addr == CFG_RADIUS_MIN) min_reg = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(logic [26:0] thr, logic [26:0] rmin, int n_items);
        write_reg(CFG_RADIUS_THRESH, thr);
        write_reg(CFG_RADIUS_MIN, rmin);
        push_random_paths(n_items);
        wait_quiet();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        thresh_reg = 27'd20000;
        min_reg    = 27'd6000;
        clear_path_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single point, two points, a tight three-point turn
        push_point(0, 0, 1);
        push_point(100, -100, 0);
        push_point(200, 300, 1);
        push_point(0, 0, 0);
        push_point(1000, 0, 0);
        push_point(2000, 1000, 1);
        // collinear, then coincident
        for (int i = 0; i < 5; i++) push_point(i * 700, -i * 300, i == 4);
        for (int i = 0; i < 4; i++) push_point(-5, 9, i == 3);
        // coordinate extremes
        push_point(32'sh80000000, 32'sh80000000, 0);
        push_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        push_point(32'sh80000000, 32'sh7FFFFFFF, 0);
        push_point(32'sh7FFFFFFF, 32'sh80000000, 0);
        push_point(0, 0, 1);
        // random walk, where a curve may start and end inside the path or be left open at the end
        push_walk(12);
        wait_quiet();
        push_random_paths(50);
        wait_quiet();

        // zero threshold, huge threshold, saturated radius, small threshold, reset values
        run_phase(27'd0, 27'd0, 40);
        run_phase(27'd100000000, 27'd100000000, 40);
        run_phase(27'h7FFFFFF, 27'h7FFFFFF, 30);
        run_phase(27'd5000, 27'd4000, 80);
        run_phase(27'd20000, 27'd6000, 40);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pcsd_pkg.sv
rtl/core/pcsd_mul.sv
rtl/core/pcsd_isqrt.sv
rtl/core/pcsd_div.sv
rtl/core/pcsd_radius.sv
rtl/core/path_curve_segment_detector.sv
tb/path_curve_segment_detector_tb.sv
